// ----- sv/tfdd_pkg.sv -----
// Shared types, constants and lookup functions for the texture format descriptor decoder.
`default_nettype none

package tfdd_pkg;

  localparam int FMT_W           = 8;
  localparam int DIM_W           = 16;
  localparam int CODE16_W        = 16;
  localparam int BLK_W           = 4;
  localparam int BYTES_W         = 5;
  localparam int LEVEL_W         = 34;
  localparam int IN_TDATA_W      = 40;
  localparam int OUT_TDATA_W     = 96;
  localparam int OUT_TUSER_W     = 3;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 1;
  localparam int DIM_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int RECIP_W         = 21;
  localparam int RECIP_SHIFT     = 20;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = {LEVEL_W{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAP_ASTC = 2'd0,
    CFG_CAP_BPTC = 2'd1,
    CFG_CAP_ETC2 = 2'd2,
    CFG_CAP_S3TC = 2'd3
  } cfg_idx_t;

  // Source format codes
  localparam logic [FMT_W-1:0] FMT_RGB8        = 8'd23;
  localparam logic [FMT_W-1:0] FMT_RGB8_SRGB   = 8'd29;
  localparam logic [FMT_W-1:0] FMT_RGBA8       = 8'd37;
  localparam logic [FMT_W-1:0] FMT_RGBA8_SRGB  = 8'd43;
  localparam logic [FMT_W-1:0] FMT_BC1         = 8'd131;
  localparam logic [FMT_W-1:0] FMT_BC1_SRGB    = 8'd132;
  localparam logic [FMT_W-1:0] FMT_BC1A        = 8'd133;
  localparam logic [FMT_W-1:0] FMT_BC1A_SRGB   = 8'd134;
  localparam logic [FMT_W-1:0] FMT_BC2         = 8'd135;
  localparam logic [FMT_W-1:0] FMT_BC2_SRGB    = 8'd136;
  localparam logic [FMT_W-1:0] FMT_BC3         = 8'd137;
  localparam logic [FMT_W-1:0] FMT_BC3_SRGB    = 8'd138;
  localparam logic [FMT_W-1:0] FMT_BC7         = 8'd145;
  localparam logic [FMT_W-1:0] FMT_BC7_SRGB    = 8'd146;
  localparam logic [FMT_W-1:0] FMT_ETC2_RGB8   = 8'd147;
  localparam logic [FMT_W-1:0] FMT_ETC2_SRGB8  = 8'd148;
  localparam logic [FMT_W-1:0] FMT_ETC2_RGB8A1 = 8'd149;
  localparam logic [FMT_W-1:0] FMT_ETC2_SRGB8A1 = 8'd150;
  localparam logic [FMT_W-1:0] FMT_ETC2_RGBA8  = 8'd151;
  localparam logic [FMT_W-1:0] FMT_ETC2_SRGBA8 = 8'd152;
  localparam logic [FMT_W-1:0] FMT_ASTC_FIRST  = 8'd157;
  localparam logic [FMT_W-1:0] FMT_ASTC_LAST   = 8'd184;

  // Legacy API enumerants
  localparam logic [CODE16_W-1:0] GL_RGB8          = 16'h8051;
  localparam logic [CODE16_W-1:0] GL_SRGB8         = 16'h8C41;
  localparam logic [CODE16_W-1:0] GL_RGBA8         = 16'h8058;
  localparam logic [CODE16_W-1:0] GL_SRGB8_ALPHA8  = 16'h8C43;
  localparam logic [CODE16_W-1:0] GL_RGB           = 16'h1907;
  localparam logic [CODE16_W-1:0] GL_RGBA          = 16'h1908;
  localparam logic [CODE16_W-1:0] GL_UNSIGNED_BYTE = 16'h1401;
  localparam logic [CODE16_W-1:0] GL_DXT1          = 16'h83F0;
  localparam logic [CODE16_W-1:0] GL_DXT1_SRGB     = 16'h8C4C;
  localparam logic [CODE16_W-1:0] GL_DXT1A         = 16'h83F1;
  localparam logic [CODE16_W-1:0] GL_DXT1A_SRGB    = 16'h8C4D;
  localparam logic [CODE16_W-1:0] GL_DXT3          = 16'h83F2;
  localparam logic [CODE16_W-1:0] GL_DXT3_SRGB     = 16'h8C4E;
  localparam logic [CODE16_W-1:0] GL_DXT5          = 16'h83F3;
  localparam logic [CODE16_W-1:0] GL_DXT5_SRGB     = 16'h8C4F;
  localparam logic [CODE16_W-1:0] GL_BPTC          = 16'h8E8C;
  localparam logic [CODE16_W-1:0] GL_BPTC_SRGB     = 16'h8E8D;
  localparam logic [CODE16_W-1:0] GL_ETC2_RGB8     = 16'h9274;
  localparam logic [CODE16_W-1:0] GL_ETC2_SRGB8    = 16'h9275;
  localparam logic [CODE16_W-1:0] GL_ETC2_RGB8A1   = 16'h9276;
  localparam logic [CODE16_W-1:0] GL_ETC2_SRGB8A1  = 16'h9277;
  localparam logic [CODE16_W-1:0] GL_ETC2_RGBA8    = 16'h9278;
  localparam logic [CODE16_W-1:0] GL_ETC2_SRGBA8   = 16'h9279;
  localparam logic [CODE16_W-1:0] GL_ASTC_UNORM    = 16'h93B0;
  localparam logic [CODE16_W-1:0] GL_ASTC_SRGB     = 16'h93D0;

  typedef struct packed {
    logic astc;
    logic bptc;
    logic etc2;
    logic s3tc;
  } caps_t;

  typedef struct packed {
    logic [CODE16_W-1:0] ifmt;
    logic [CODE16_W-1:0] base;
    logic [CODE16_W-1:0] ptype;
    logic [BLK_W-1:0]    bw;
    logic [BLK_W-1:0]    bh;
    logic [BYTES_W-1:0]  bytes;
    logic                comp;
    logic                valid;
    logic                sup;
  } desc_t;

  // Queue entry between classifier and size pipeline
  typedef struct packed {
    desc_t            d;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } qent_t;

  // Footprint divisor split as 2^k * m, m odd
  typedef struct packed {
    logic [1:0] k;
    logic [2:0] m;
  } split_t;

  // ASTC footprint, returns {bw, bh}
  function automatic logic [2*BLK_W-1:0] astc_foot(input logic [3:0] idx);
    logic [2*BLK_W-1:0] f;
    unique case (idx)
      4'd0:    f = {4'd4,  4'd4};
      4'd1:    f = {4'd5,  4'd4};
      4'd2:    f = {4'd5,  4'd5};
      4'd3:    f = {4'd6,  4'd5};
      4'd4:    f = {4'd6,  4'd6};
      4'd5:    f = {4'd8,  4'd5};
      4'd6:    f = {4'd8,  4'd6};
      4'd7:    f = {4'd8,  4'd8};
      4'd8:    f = {4'd10, 4'd5};
      4'd9:    f = {4'd10, 4'd6};
      4'd10:   f = {4'd10, 4'd8};
      4'd11:   f = {4'd10, 4'd10};
      4'd12:   f = {4'd12, 4'd10};
      4'd13:   f = {4'd12, 4'd12};
      default: f = '0;
    endcase
    return f;
  endfunction

  function automatic split_t split_div(input logic [BLK_W-1:0] b);
    split_t s;
    unique case (b)
      4'd4:    s = '{k: 2'd2, m: 3'd1};
      4'd5:    s = '{k: 2'd0, m: 3'd5};
      4'd6:    s = '{k: 2'd1, m: 3'd3};
      4'd8:    s = '{k: 2'd3, m: 3'd1};
      4'd10:   s = '{k: 2'd1, m: 3'd5};
      4'd12:   s = '{k: 2'd2, m: 3'd3};
      default: s = '{k: 2'd0, m: 3'd1};
    endcase
    return s;
  endfunction

  // Scaled reciprocal of the odd divisor; estimate lands on q or q-1
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] m);
    logic [RECIP_W-1:0] r;
    unique case (m)
      3'd3:    r = 21'd349525;
      3'd5:    r = 21'd209715;
      default: r = 21'd1048576;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/tfdd_front.sv -----
// Front end: capability registers, input handshake and format classification.
`default_nettype none

module tfdd_front #(
  parameter int DIM_BITS = tfdd_pkg::DIM_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [tfdd_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [tfdd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [tfdd_pkg::IN_TDATA_W-1:0]  in_data,
  input  wire logic                             q_full,
  output logic                                  push,
  output tfdd_pkg::qent_t                       push_ent
);
  import tfdd_pkg::*;

  caps_t               caps;
  logic [FMT_W-1:0]    code;
  logic [DIM_W-1:0]    dmask;
  logic [FMT_W-1:0]    off;
  logic [3:0]          idx;
  logic [2*BLK_W-1:0]  foot;
  desc_t               d;

  function automatic desc_t mk_plain(input logic [CODE16_W-1:0] ifmt,
                                     input logic [CODE16_W-1:0] base,
                                     input logic [BYTES_W-1:0] bytes);
    desc_t r;
    r.ifmt  = ifmt;
    r.base  = base;
    r.ptype = GL_UNSIGNED_BYTE;
    r.bw    = 4'd1;
    r.bh    = 4'd1;
    r.bytes = bytes;
    r.comp  = 1'b0;
    r.valid = 1'b1;
    r.sup   = 1'b1;
    return r;
  endfunction

  function automatic desc_t mk_block(input logic [CODE16_W-1:0] ifmt,
                                     input logic [BYTES_W-1:0] bytes,
                                     input logic cap);
    desc_t r;
    r.ifmt  = ifmt;
    r.base  = '0;
    r.ptype = '0;
    r.bw    = 4'd4;
    r.bh    = 4'd4;
    r.bytes = bytes;
    r.comp  = 1'b1;
    r.valid = 1'b1;
    r.sup   = cap;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      caps <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_CAP_ASTC: caps.astc <= cfg_wdata[0];
        CFG_CAP_BPTC: caps.bptc <= cfg_wdata[0];
        CFG_CAP_ETC2: caps.etc2 <= cfg_wdata[0];
        CFG_CAP_S3TC: caps.s3tc <= cfg_wdata[0];
      endcase
    end
  end

  assign code = in_data[FMT_W-1:0];

  always_comb begin
    for (int i = 0; i < DIM_W; i++) begin
      dmask[i] = (i < DIM_BITS);
    end
  end

  always_comb begin
    off  = code - FMT_ASTC_FIRST;
    idx  = off[4:1];
    foot = astc_foot(idx);
    d    = '0;
    unique case (code)
      FMT_RGB8:         d = mk_plain(GL_RGB8, GL_RGB, 5'd3);
      FMT_RGB8_SRGB:    d = mk_plain(GL_SRGB8, GL_RGB, 5'd3);
      FMT_RGBA8:        d = mk_plain(GL_RGBA8, GL_RGBA, 5'd4);
      FMT_RGBA8_SRGB:   d = mk_plain(GL_SRGB8_ALPHA8, GL_RGBA, 5'd4);
      FMT_BC1:          d = mk_block(GL_DXT1, 5'd8, caps.s3tc);
      FMT_BC1_SRGB:     d = mk_block(GL_DXT1_SRGB, 5'd8, caps.s3tc);
      FMT_BC1A:         d = mk_block(GL_DXT1A, 5'd8, caps.s3tc);
      FMT_BC1A_SRGB:    d = mk_block(GL_DXT1A_SRGB, 5'd8, caps.s3tc);
      FMT_BC2:          d = mk_block(GL_DXT3, 5'd16, caps.s3tc);
      FMT_BC2_SRGB:     d = mk_block(GL_DXT3_SRGB, 5'd16, caps.s3tc);
      FMT_BC3:          d = mk_block(GL_DXT5, 5'd16, caps.s3tc);
      FMT_BC3_SRGB:     d = mk_block(GL_DXT5_SRGB, 5'd16, caps.s3tc);
      FMT_BC7:          d = mk_block(GL_BPTC, 5'd16, caps.bptc);
      FMT_BC7_SRGB:     d = mk_block(GL_BPTC_SRGB, 5'd16, caps.bptc);
      FMT_ETC2_RGB8:    d = mk_block(GL_ETC2_RGB8, 5'd8, caps.etc2);
      FMT_ETC2_SRGB8:   d = mk_block(GL_ETC2_SRGB8, 5'd8, caps.etc2);
      FMT_ETC2_RGB8A1:  d = mk_block(GL_ETC2_RGB8A1, 5'd8, caps.etc2);
      FMT_ETC2_SRGB8A1: d = mk_block(GL_ETC2_SRGB8A1, 5'd8, caps.etc2);
      FMT_ETC2_RGBA8:   d = mk_block(GL_ETC2_RGBA8, 5'd16, caps.etc2);
      FMT_ETC2_SRGBA8:  d = mk_block(GL_ETC2_SRGBA8, 5'd16, caps.etc2);
      default: begin
        if (code >= FMT_ASTC_FIRST && code <= FMT_ASTC_LAST) begin
          d    = mk_block((off[0] ? GL_ASTC_SRGB : GL_ASTC_UNORM) + {12'd0, idx},
                          5'd16, caps.astc);
          d.bw = foot[2*BLK_W-1:BLK_W];
          d.bh = foot[BLK_W-1:0];
        end
      end
    endcase
  end

  assign in_ready   = !q_full;
  assign push       = in_valid && !q_full;
  assign push_ent.d = d;
  assign push_ent.w = in_data[FMT_W +: DIM_W] & dmask;
  assign push_ent.h = in_data[FMT_W+DIM_W +: DIM_W] & dmask;

endmodule

`default_nettype wire

// ----- sv/tfdd_queue.sv -----
// Small FIFO that decouples the classifier from the size pipeline.
`default_nettype none

module tfdd_queue #(
  parameter int DEPTH = tfdd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire tfdd_pkg::qent_t wr_ent,
  output logic                 full,
  input  wire logic            pop,
  output tfdd_pkg::qent_t      rd_ent,
  output logic                 not_empty
);
  import tfdd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_ent    = mem[rd_ptr];

endmodule

`default_nettype wire

// ----- sv/tfdd_back.sv -----
// Back end: level byte-size pipeline and registered output stage.
`default_nettype none

module tfdd_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_valid,
  input  wire tfdd_pkg::qent_t                   q_ent,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [tfdd_pkg::OUT_TDATA_W-1:0]       out_data,
  output logic [tfdd_pkg::OUT_TUSER_W-1:0]       out_user
);
  import tfdd_pkg::*;

  localparam int UW = DIM_W + 1;
  localparam int PRW = UW + RECIP_W;
  localparam int FW = 2 * DIM_W + BYTES_W;

  typedef struct packed {
    desc_t d;
    logic  zero;
  } meta_t;

  logic                adv;
  split_t              sx, sy;
  logic [UW-1:0]       tx, ty, ux, uy;
  logic [PRW-1:0]      px, py;
  logic [UW-1:0]       rx, ry;
  logic [DIM_W-1:0]    bx, by;
  logic [FW-1:0]       full_bytes;
  logic [LEVEL_W-1:0]  lb;

  logic                a_v, b_v, c_v, d_v;
  meta_t               a_m, b_m, c_m, d_m;
  logic [UW-1:0]       a_ux, a_uy, b_ux, b_uy, b_qx, b_qy;
  logic [2:0]          a_mx, a_my, b_mx, b_my;
  logic [DIM_W-1:0]    c_bx, c_by;
  logic [2*DIM_W-1:0]  d_p;
  desc_t               o_d;
  logic [LEVEL_W-1:0]  o_lb;

  // Advance the whole pipe when the output register is free or being taken
  assign adv = !out_valid || out_ready;
  assign pop = adv && q_valid;

  // Stage A: ceil over the power-of-two part, then bias for the odd part
  always_comb begin
    sx = split_div(q_ent.d.bw);
    sy = split_div(q_ent.d.bh);
    tx = ({1'b0, q_ent.w} + ((UW'(1) << sx.k) - UW'(1))) >> sx.k;
    ty = ({1'b0, q_ent.h} + ((UW'(1) << sy.k) - UW'(1))) >> sy.k;
    ux = tx + UW'(sx.m) - UW'(1);
    uy = ty + UW'(sy.m) - UW'(1);
  end

  // Stage B: reciprocal estimate
  assign px = PRW'(a_ux) * PRW'(recip(a_mx));
  assign py = PRW'(a_uy) * PRW'(recip(a_my));

  // Stage C: one-step correction of the estimate
  always_comb begin
    rx = b_ux - UW'(b_qx * UW'(b_mx));
    ry = b_uy - UW'(b_qy * UW'(b_my));
    bx = DIM_W'((rx >= UW'(b_mx)) ? b_qx + UW'(1) : b_qx);
    by = DIM_W'((ry >= UW'(b_my)) ? b_qy + UW'(1) : b_qy);
  end

  // Stage E: scale by block bytes and saturate; zero for an unknown format or an empty level
  always_comb begin
    full_bytes = FW'(d_p) * FW'(d_m.d.bytes);
    if (!d_m.d.valid || d_m.zero) begin
      lb = '0;
    end else if (full_bytes > FW'(LEVEL_MAX)) begin
      lb = LEVEL_MAX;
    end else begin
      lb = full_bytes[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      d_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_v       <= q_valid;
      b_v       <= a_v;
      c_v       <= b_v;
      d_v       <= c_v;
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_m.d    <= q_ent.d;
      a_m.zero <= (q_ent.w == '0) || (q_ent.h == '0);
      a_ux     <= ux;
      a_uy     <= uy;
      a_mx     <= sx.m;
      a_my     <= sy.m;
      b_m      <= a_m;
      b_ux     <= a_ux;
      b_uy     <= a_uy;
      b_mx     <= a_mx;
      b_my     <= a_my;
      b_qx     <= px[RECIP_SHIFT +: UW];
      b_qy     <= py[RECIP_SHIFT +: UW];
      c_m      <= b_m;
      c_bx     <= bx;
      c_by     <= by;
      d_m      <= c_m;
      d_p      <= (2*DIM_W)'(c_bx) * (2*DIM_W)'(c_by);
      o_d      <= d_m.d;
      o_lb     <= lb;
    end
  end

  assign out_data = {1'b0, o_lb, o_d.bytes, o_d.bh, o_d.bw, o_d.ptype, o_d.base, o_d.ifmt};
  assign out_user = {o_d.valid && o_d.sup, o_d.valid, o_d.comp};

endmodule

`default_nettype wire

// ----- sv/texture_format_descriptor_decode_core.sv -----
// Top level of the texture format descriptor decoder.
// A request accepted on s_axis passes through the queue, four size-pipeline stages and
//   one output register before its result shows on m_axis.
// Throughput: one request per cycle, sustained while m_axis_tready stays high.
// Reset (rst, synchronous, active high) clears the capability registers, the queue
//   and every pipeline valid bit; payload registers are not reset.
`default_nettype none

module texture_format_descriptor_decode_core #(
  parameter int DIM_BITS    = tfdd_pkg::DIM_BITS_DEF,
  parameter int QUEUE_DEPTH = tfdd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Capability register writes (index per cfg_idx_t)
  input  wire logic                               cfg_we,
  input  wire logic [tfdd_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [tfdd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Request stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // [7:0] format_code, [23:8] level_width, [39:24] level_height
  input  wire logic [tfdd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Result stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // [15:0] internal_format, [31:16] upload_base_format, [47:32] upload_pixel_type,
  // [51:48] block_w, [55:52] block_h, [60:56] block_size_bytes,
  // [94:61] level_bytes, [95] zero pad
  output logic [tfdd_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // [0] is_compressed, [1] is_valid, [2] is_supported
  output logic [tfdd_pkg::OUT_TUSER_W-1:0]        m_axis_tuser
);
  import tfdd_pkg::*;

  logic  push;
  logic  q_full;
  logic  q_not_empty;
  logic  pop;
  qent_t push_ent;
  qent_t head_ent;

  // Front: hold capability bits, classify the format code, mask the dimensions
  // to DIM_BITS and push one entry per accepted request.
  tfdd_front #(
    .DIM_BITS (DIM_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  // Queue: lets the front keep accepting while the output side stalls.
  tfdd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_ent   (push_ent),
    .full     (q_full),
    .pop      (pop),
    .rd_ent   (head_ent),
    .not_empty(q_not_empty)
  );

  // Back: ceil(w/bw) and ceil(h/bh) by shift plus reciprocal multiply,
  // product of block counts, scale by block bytes with saturation at 2^34-1.
  tfdd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_not_empty),
    .q_ent    (head_ent),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (m_axis_tdata),
    .out_user (m_axis_tuser)
  );

  // Supported implies recognized
  a_sup_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
    else $error("supported result on an unrecognized format");

  // Unknown code yields an all-zero descriptor and zero bytes
  a_unknown_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> (m_axis_tdata == '0) && (m_axis_tuser == '0))
    else $error("unknown format produced nonzero fields");

  // Compressed formats carry no upload base format or pixel type
  a_comp_no_upload: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata[47:16] == '0))
    else $error("compressed format with upload fields set");

  // No result can be presented in the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // Queue push only when the front reported space
  a_push_space: assert property (@(posedge clk) disable iff (rst)
    push |-> s_axis_tready && !q_full)
    else $error("queue push while full");

endmodule

`default_nettype wire
